@@ sv/bxfs_pkg.sv @@
// Shared constants and helper functions for the box-average error-diffusion ditherer.
package bxfs_pkg;

    localparam int MAX_WIDTH_DEF     = 512;
    localparam int MAX_HEIGHT_DEF    = 512;
    localparam int MAX_BOX_COUNT_DEF = 4096;

    localparam int GREY_W   = 8;
    localparam int GREY_MAX = 255;
    localparam int THRESH   = 128;

    localparam int ERR_W   = 13;
    localparam int ERR_MAX = 2 ** (ERR_W - 1) - 1;
    localparam int ERR_MIN = -(2 ** (ERR_W - 1));
    localparam int WORK_W  = 16;

    localparam int FRAC_SHIFT = 4;
    localparam int FRAC_ONE   = 16;

    localparam int WGT_RIGHT      = 7;
    localparam int WGT_BELOW_LEFT = 3;
    localparam int WGT_BELOW      = 5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INK        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd3;

    localparam int RST_ROW_WIDTH  = 320;
    localparam int RST_ROW_COUNT  = 240;
    localparam int RST_INK        = 0;
    localparam int RST_BACKGROUND = 255;

    // divide by 16, rounding toward zero
    function automatic logic signed [WORK_W-1:0] div16_trunc(input logic signed [WORK_W-1:0] v);
        logic signed [WORK_W-1:0] adj;
        adj = v[WORK_W-1] ? v + WORK_W'(FRAC_ONE - 1) : v;
        return adj >>> FRAC_SHIFT;
    endfunction

    function automatic logic [ERR_W-1:0] sat_err(input logic signed [WORK_W-1:0] v);
        logic [ERR_W-1:0] res;
        if (v > $signed(WORK_W'(ERR_MAX))) begin
            res = ERR_W'(ERR_MAX);
        end else if (v < $signed(WORK_W'(ERR_MIN))) begin
            res = ERR_W'(ERR_MIN);
        end else begin
            res = v[ERR_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ sv/box_average_floyd_steinberg_dither.sv @@
// Box-average 1bpp error-diffusion ditherer, top level.
// Each input beat runs the 8-step divider (skipped if the average saturates), then the
// calc state, held on output stall; the next beat waits until the result is registered.
// A row's last pixel adds the tail states to flush next-row error into the line store.
// Synchronous reset: positions, fill count and config registers; no clearing pass needed.
module box_average_floyd_steinberg_dither #(
    parameter int  MAX_WIDTH     = bxfs_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT    = bxfs_pkg::MAX_HEIGHT_DEF,
    parameter int  MAX_BOX_COUNT = bxfs_pkg::MAX_BOX_COUNT_DEF,
    localparam int SUM_W = $clog2(MAX_BOX_COUNT * bxfs_pkg::GREY_MAX + 1),
    localparam int CNT_W = $clog2(MAX_BOX_COUNT + 1),
    localparam int WID_W = $clog2(MAX_WIDTH + 1),
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1),
    localparam int DIM_W = (WID_W > HGT_W) ? WID_W : HGT_W,
    localparam int CFG_W = (DIM_W > bxfs_pkg::GREY_W) ? DIM_W : bxfs_pkg::GREY_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [SUM_W-1:0]               i_box_sum,
    input  logic [CNT_W-1:0]               i_box_count,
    input  logic                           i_covered,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bxfs_pkg::GREY_W-1:0]    o_pixel_value,
    output logic                           o_is_ink,
    output logic                           o_frame_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bxfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]               i_cfg_data
);
    import bxfs_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_TAIL0 = 3'd3;
    localparam logic [2:0] ST_TAIL1 = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [WID_W-1:0]  r_row_width;
    logic [HGT_W-1:0]  r_row_count;
    logic [GREY_W-1:0] r_ink_value;
    logic [GREY_W-1:0] r_bg_value;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_tail_col;
    logic [WID_W-1:0] r_fill;
    logic             r_covered;
    logic             r_rd_ok;

    logic signed [WORK_W-1:0] r_carry;
    logic signed [WORK_W-1:0] r_a1;
    logic signed [WORK_W-1:0] r_a2;

    logic              r_out_valid;
    logic [GREY_W-1:0] r_pixel_value;
    logic              r_is_ink;
    logic              r_frame_end;

    logic              s_accept;
    logic              s_out_free;
    logic              s_calc_go;
    logic              w_div_done;
    logic [GREY_W-1:0] w_grey;
    logic [ERR_W-1:0]  w_mem_rdata;

    logic              s_mem_we;
    logic [COL_W-1:0]  s_mem_waddr;
    logic [ERR_W-1:0]  s_mem_wdata;

    logic [WID_W-1:0]   s_eff_w;
    logic [HGT_W-1:0]   s_eff_h;
    logic               s_row_end;
    logic               s_frame_end;
    logic [COL_W+1:0]   s_col_p2;
    logic [WID_W-1:0]   s_fill;

    logic signed [WORK_W-1:0] s_rd;
    logic signed [WORK_W-1:0] s_total;
    logic signed [WORK_W-1:0] s_q16;
    logic signed [WORK_W-1:0] s_wanted;
    logic                     s_ink;
    logic signed [WORK_W-1:0] s_e;
    logic signed [WORK_W-1:0] s_c3;
    logic signed [WORK_W-1:0] s_c5;
    logic signed [WORK_W-1:0] s_c7;

    assign s_accept   = i_valid && (r_state == ST_IDLE);
    assign s_out_free = !r_out_valid || !i_stall;
    assign s_calc_go  = (r_state == ST_CALC) && s_out_free;

    bxfs_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_sum   (i_box_sum),
        .i_cnt   (i_box_count),
        .o_done  (w_div_done),
        .o_quot  (w_grey)
    );

    bxfs_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (ERR_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (s_mem_waddr),
        .i_wdata (s_mem_wdata),
        .i_re    (s_accept),
        .i_raddr (r_col),
        .o_rdata (w_mem_rdata)
    );

    always_comb begin
        if (r_row_width == '0) begin
            s_eff_w = WID_W'(1);
        end else if (r_row_width > WID_W'(MAX_WIDTH)) begin
            s_eff_w = WID_W'(MAX_WIDTH);
        end else begin
            s_eff_w = r_row_width;
        end
        if (r_row_count == '0) begin
            s_eff_h = HGT_W'(1);
        end else if (r_row_count > HGT_W'(MAX_HEIGHT)) begin
            s_eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            s_eff_h = r_row_count;
        end
    end

    assign s_row_end   = ({1'b0, r_col} + 1'b1) >= (COL_W + 1)'(s_eff_w);
    assign s_frame_end = s_row_end && (({1'b0, r_row} + 1'b1) >= (ROW_W + 1)'(s_eff_h));
    assign s_col_p2    = (COL_W + 2)'(r_col) + (COL_W + 2)'(2);
    assign s_fill      = (s_col_p2 >= (COL_W + 2)'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH)
                                                                : WID_W'(s_col_p2);

    // error arithmetic, in 1/16 grey units
    always_comb begin
        s_rd     = r_rd_ok ? WORK_W'($signed(w_mem_rdata)) : '0;
        s_total  = s_rd + r_carry;
        s_q16    = div16_trunc(s_total);
        s_wanted = $signed(WORK_W'(w_grey)) + s_q16;
        s_ink    = r_covered && (s_wanted < $signed(WORK_W'(THRESH)));
        if (!r_covered) begin
            s_e = '0;
        end else if (s_ink) begin
            s_e = s_wanted;
        end else begin
            s_e = s_wanted - $signed(WORK_W'(GREY_MAX));
        end
        s_c3 = s_e * $signed(WORK_W'(WGT_BELOW_LEFT));
        s_c5 = s_e * $signed(WORK_W'(WGT_BELOW));
        s_c7 = s_e * $signed(WORK_W'(WGT_RIGHT));
    end

    // write back completed next-row entries
    always_comb begin
        s_mem_we    = 1'b0;
        s_mem_waddr = r_col - 1'b1;
        s_mem_wdata = sat_err(r_a1 + s_c3);
        case (r_state)
            ST_CALC: begin
                s_mem_we = s_calc_go && (r_col != '0);
            end
            ST_TAIL0: begin
                s_mem_we    = 1'b1;
                s_mem_waddr = r_tail_col;
                s_mem_wdata = sat_err(r_a1);
            end
            ST_TAIL1: begin
                s_mem_we    = r_tail_col != COL_W'(MAX_WIDTH - 1);
                s_mem_waddr = r_tail_col + 1'b1;
                s_mem_wdata = sat_err(r_a2);
            end
            default: begin
                s_mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (s_out_free) begin
                    n_state = s_row_end ? ST_TAIL0 : ST_IDLE;
                end
            end
            ST_TAIL0: begin
                n_state = ST_TAIL1;
            end
            ST_TAIL1: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_width <= WID_W'(RST_ROW_WIDTH);
            r_row_count <= HGT_W'(RST_ROW_COUNT);
            r_ink_value <= GREY_W'(RST_INK);
            r_bg_value  <= GREY_W'(RST_BACKGROUND);
            r_col       <= '0;
            r_row       <= '0;
            r_fill      <= '0;
            r_carry     <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROW_WIDTH:  r_row_width <= i_cfg_data[WID_W-1:0];
                    CFG_ROW_COUNT:  r_row_count <= i_cfg_data[HGT_W-1:0];
                    CFG_INK:        r_ink_value <= i_cfg_data[GREY_W-1:0];
                    CFG_BACKGROUND: r_bg_value  <= i_cfg_data[GREY_W-1:0];
                    default:        r_bg_value  <= r_bg_value;
                endcase
            end

            if (s_calc_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (s_calc_go) begin
                r_a1        <= r_a2 + s_c5;
                r_a2        <= s_e;
                if (s_row_end) begin
                    r_col   <= '0;
                    r_carry <= '0;
                    if (s_frame_end) begin
                        r_row  <= '0;
                        r_fill <= '0;
                    end else begin
                        r_row  <= r_row + 1'b1;
                        r_fill <= s_fill;
                    end
                end else begin
                    r_col   <= r_col + 1'b1;
                    r_carry <= s_c7;
                end
            end

            if (r_state == ST_TAIL1) begin
                r_a1 <= '0;
                r_a2 <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_covered <= i_covered;
            r_rd_ok   <= (COL_W + 1)'(r_col) < (COL_W + 1)'(r_fill);
        end
        if (s_calc_go) begin
            r_tail_col    <= r_col;
            r_pixel_value <= s_ink ? r_ink_value : r_bg_value;
            r_is_ink      <= s_ink;
            r_frame_end   <= s_frame_end;
        end
    end

    assign o_stall       = r_state != ST_IDLE;
    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_pixel_value;
    assign o_is_ink      = r_is_ink;
    assign o_frame_end   = r_frame_end;
    assign o_cfg_ready   = 1'b1;

endmodule

@@ sv/bxfs_div.sv @@
// Iterative restoring divider giving the saturated 8-bit box average, one bit per cycle.
module bxfs_div #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [SUM_W-1:0]            i_sum,
    input  logic [CNT_W-1:0]            i_cnt,
    output logic                        o_done,
    output logic [bxfs_pkg::GREY_W-1:0] o_quot
);
    import bxfs_pkg::*;

    localparam int CMP_W  = (SUM_W > CNT_W + GREY_W) ? SUM_W : CNT_W + GREY_W;
    localparam int STEP_W = $clog2(GREY_W);

    logic              r_busy;
    logic              r_done;
    logic              r_sat;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_rem;
    logic [CMP_W-1:0]  r_den;
    logic [GREY_W-1:0] r_quot;

    logic s_sat;
    logic s_ge;

    // quotient above 255 (or a zero count) saturates
    assign s_sat = CMP_W'(i_sum) >= (CMP_W'(i_cnt) << GREY_W);
    assign s_ge  = CMP_W'(r_rem) >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= !s_sat;
            r_done <= s_sat;
        end else if (r_busy && r_step == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= s_sat;
            r_rem  <= i_sum;
            r_den  <= CMP_W'(i_cnt) << (GREY_W - 1);
            r_step <= STEP_W'(GREY_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (s_ge) begin
                r_rem <= r_rem - r_den[SUM_W-1:0];
            end
            r_quot <= {r_quot[GREY_W-2:0], s_ge};
            r_den  <= r_den >> 1;
            r_step <= r_step - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? GREY_W'(GREY_MAX) : r_quot;

endmodule

@@ sv/bxfs_line_mem.sv @@
// Single-port-write, single-port-read line store for next-row diffused error.
module bxfs_line_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
